/* hw/rtl/apet_pkg.sv */
package apet_pkg;

  localparam int SCREEN_WIDTH  = 1024;
  localparam int SCREEN_HEIGHT = 768;
  localparam int SCREEN_MAX    = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;

  // size-1 and every quotient fit in MUL_W bits
  localparam int MUL_W     = $clog2(SCREEN_MAX);
  localparam int RAW_W     = 32;
  localparam int ACC_W     = RAW_W + MUL_W;
  localparam int CNT_W     = $clog2(MUL_W + 1);
  localparam int COORD_W   = 10;
  localparam int BTN_W     = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [15:0] EVT_SYNC   = 16'h0000;
  localparam logic [15:0] EVT_KEY    = 16'h0001;
  localparam logic [15:0] EVT_ABS    = 16'h0003;
  localparam logic [15:0] AXIS_X     = 16'h0000;
  localparam logic [15:0] AXIS_Y     = 16'h0001;
  localparam logic [15:0] KEY_LEFT   = 16'h0110;
  localparam logic [15:0] KEY_RIGHT  = 16'h0111;
  localparam logic [15:0] KEY_MIDDLE = 16'h0112;

  localparam logic [RAW_W-1:0] FALLBACK_MAX = 32'h0000_FFFF;
  localparam logic [RAW_W-1:0] X_MAX_RESET  = FALLBACK_MAX;
  localparam logic [RAW_W-1:0] Y_MAX_RESET  = FALLBACK_MAX;

  localparam logic [MUL_W-1:0] MULT_X = MUL_W'(SCREEN_WIDTH - 1);
  localparam logic [MUL_W-1:0] MULT_Y = MUL_W'(SCREEN_HEIGHT - 1);

  localparam logic [COORD_W-1:0] COL_RESET = COORD_W'(SCREEN_WIDTH / 2);
  localparam logic [COORD_W-1:0] ROW_RESET = COORD_W'(SCREEN_HEIGHT / 2);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_MIN = 2'd0,
    REG_X_MAX = 2'd1,
    REG_Y_MIN = 2'd2,
    REG_Y_MAX = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    SC_IDLE,
    SC_CLAMP,
    SC_SUB,
    SC_MUL,
    SC_DIV,
    SC_DONE
  } sc_state_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCALE
  } ctl_state_t;

  typedef struct packed {
    logic [15:0]      event_type;
    logic [15:0]      event_code;
    logic [RAW_W-1:0] event_value;
  } event_t;

  typedef struct packed {
    logic [COORD_W-1:0] cursor_x;
    logic [COORD_W-1:0] cursor_y;
    logic [BTN_W-1:0]   button_mask;
  } result_t;

  typedef struct packed {
    logic             start;
    logic [RAW_W-1:0] raw;
    logic [RAW_W-1:0] lo;
    logic [RAW_W-1:0] hi;
    logic [MUL_W-1:0] mult;
  } scale_req_t;

  typedef struct packed {
    logic             done;
    logic [MUL_W-1:0] quot;
  } scale_rsp_t;

  function automatic logic [COORD_W-1:0] to_coord(input logic [MUL_W-1:0] q);
    logic [MUL_W+COORD_W-1:0] w;
    w = (MUL_W + COORD_W)'(q);
    return w[COORD_W-1:0];
  endfunction

endpackage

/* hw/rtl/apet_scaler.sv */
module apet_scaler (
  input  logic                clk,
  input  logic                rst,
  input  apet_pkg::scale_req_t req,
  output apet_pkg::scale_rsp_t rsp
);
  import apet_pkg::*;

  sc_state_t        st;
  sc_state_t        st_next;
  logic [RAW_W-1:0] raw;
  logic [RAW_W-1:0] lo;
  logic [RAW_W-1:0] hi;
  logic [RAW_W-1:0] diff;
  logic [RAW_W-1:0] span;
  logic             span_zero;
  logic [MUL_W-1:0] mult;
  logic [ACC_W-1:0] acc;
  logic [RAW_W-1:0] rem;
  logic [MUL_W-1:0] qsh;
  logic [CNT_W-1:0] cnt;
  logic             last_step;

  logic [ACC_W-1:0] acc_shift;
  logic [ACC_W-1:0] addend;
  logic [RAW_W:0]   rem_shift;
  logic [RAW_W:0]   trial;
  logic             fits;
  logic [MUL_W-1:0] q_cat;

  assign last_step = (cnt == CNT_W'(MUL_W - 1));

  // shift-add multiply, multiplier MSB first
  assign acc_shift = {acc[ACC_W-2:0], 1'b0};
  assign addend    = mult[MUL_W-1] ? ACC_W'(diff) : '0;

  // restoring divide, one quotient bit per cycle
  assign rem_shift = {rem, qsh[MUL_W-1]};
  assign trial     = rem_shift - {1'b0, span};
  assign fits      = !trial[RAW_W];
  assign q_cat     = {qsh[MUL_W-2:0], fits};

  always_comb begin
    st_next = st;
    case (st)
      SC_IDLE:  if (req.start) st_next = SC_CLAMP;
      SC_CLAMP: st_next = SC_SUB;
      SC_SUB:   st_next = SC_MUL;
      SC_MUL:   if (last_step) st_next = SC_DIV;
      SC_DIV:   if (last_step) st_next = SC_DONE;
      SC_DONE:  st_next = SC_IDLE;
      default:  st_next = SC_IDLE;
    endcase
  end

  always_comb begin
    rsp.done = (st == SC_DONE);
    rsp.quot = span_zero ? '0 : qsh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= SC_IDLE;
      cnt <= '0;
    end else begin
      st <= st_next;
      case (st)
        SC_SUB:  cnt <= '0;
        SC_MUL:  cnt <= last_step ? '0 : cnt + 1'b1;
        SC_DIV:  cnt <= cnt + 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (st)
      SC_IDLE: begin
        if (req.start) begin
          raw  <= req.raw;
          mult <= req.mult;
          // a degenerate or inverted range (hi <= lo) falls back to the full 16-bit range
          if (req.hi <= req.lo) begin
            lo <= '0;
            hi <= FALLBACK_MAX;
          end else begin
            lo <= req.lo;
            hi <= req.hi;
          end
        end
      end
      SC_CLAMP: begin
        if (raw < lo) begin
          raw <= lo;
        end else if (raw > hi) begin
          raw <= hi;
        end
      end
      SC_SUB: begin
        diff      <= raw - lo;
        span      <= hi - lo;
        span_zero <= (hi == lo);
        acc       <= '0;
      end
      SC_MUL: begin
        acc  <= acc_shift + addend;
        mult <= {mult[MUL_W-2:0], 1'b0};
        if (last_step) begin
          rem <= acc_shift[ACC_W-1:MUL_W] + addend[ACC_W-1:MUL_W]
                 + RAW_W'(({1'b0, acc_shift[MUL_W-1:0]} + {1'b0, addend[MUL_W-1:0]})
                          >> MUL_W);
          qsh <= acc_shift[MUL_W-1:0] + addend[MUL_W-1:0];
        end
      end
      SC_DIV: begin
        rem <= fits ? trial[RAW_W-1:0] : rem_shift[RAW_W-1:0];
        qsh <= q_cat;
      end
      default: begin
      end
    endcase
  end

endmodule

/* hw/rtl/absolute_pointer_event_tracker_unit.sv */
// Absolute pointer tracker: each transfer on the input channel is one input event and yields
// one result with the current cursor column, row and button mask. Key, sync and unknown
// events load the result register directly, so such events can follow each other every cycle
// while the receiver keeps up. An absolute X or Y event is clamped, offset and then scaled by the
// bit-serial shift-add multiplier and the restoring divider in the scaler, each
// producing one bit per cycle; no new event is taken until the result is loaded. A raw range
// with max <= min falls back to 0..65535. Write the range registers only while idle.
module absolute_pointer_event_tracker_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  apet_pkg::event_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output apet_pkg::result_t                   out_data,
  input  logic                                write_enable,
  input  logic [apet_pkg::CFG_IDX_W-1:0]      register_index,
  input  logic [apet_pkg::RAW_W-1:0]          write_data
);
  import apet_pkg::*;

  ctl_state_t         st;
  ctl_state_t         st_next;
  logic [RAW_W-1:0]   x_raw_min;
  logic [RAW_W-1:0]   x_raw_max;
  logic [RAW_W-1:0]   y_raw_min;
  logic [RAW_W-1:0]   y_raw_max;
  logic [COORD_W-1:0] cursor_col;
  logic [COORD_W-1:0] cursor_row;
  logic [BTN_W-1:0]   buttons;
  logic               axis_y;

  logic               in_fire;
  logic               is_abs_x;
  logic               is_abs_y;
  logic               start_scale;
  logic [BTN_W-1:0]   key_bit;
  logic [BTN_W-1:0]   buttons_next;
  logic [COORD_W-1:0] new_coord;
  scale_req_t         req;
  scale_rsp_t         rsp;

  assign in_fire  = in_valid && in_ready;
  assign is_abs_x = (in_data.event_type == EVT_ABS) && (in_data.event_code == AXIS_X);
  assign is_abs_y = (in_data.event_type == EVT_ABS) && (in_data.event_code == AXIS_Y);
  assign start_scale = in_fire && (is_abs_x || is_abs_y);

  always_comb begin
    key_bit = '0;
    if (in_data.event_type == EVT_KEY) begin
      case (in_data.event_code)
        KEY_LEFT:   key_bit = 3'b001;
        KEY_RIGHT:  key_bit = 3'b010;
        KEY_MIDDLE: key_bit = 3'b100;
        default:    key_bit = '0;
      endcase
    end
    if (in_data.event_value != '0) begin
      buttons_next = buttons | key_bit;
    end else begin
      buttons_next = buttons & ~key_bit;
    end
  end

  always_comb begin
    req.start = start_scale;
    req.raw   = in_data.event_value;
    req.lo    = is_abs_y ? y_raw_min : x_raw_min;
    req.hi    = is_abs_y ? y_raw_max : x_raw_max;
    req.mult  = is_abs_y ? MULT_Y : MULT_X;
  end

  apet_scaler u_scaler (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign new_coord = to_coord(rsp.quot);

  always_comb begin
    st_next = st;
    case (st)
      ST_IDLE:  if (start_scale) st_next = ST_SCALE;
      ST_SCALE: if (rsp.done) st_next = ST_IDLE;
      default:  st_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (st == ST_IDLE) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_raw_min <= '0;
      x_raw_max <= X_MAX_RESET;
      y_raw_min <= '0;
      y_raw_max <= Y_MAX_RESET;
    end else if (write_enable) begin
      case (reg_index_t'(register_index))
        REG_X_MIN: x_raw_min <= write_data;
        REG_X_MAX: x_raw_max <= write_data;
        REG_Y_MIN: y_raw_min <= write_data;
        REG_Y_MAX: y_raw_max <= write_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= ST_IDLE;
      cursor_col <= COL_RESET;
      cursor_row <= ROW_RESET;
      buttons    <= '0;
      out_valid  <= 1'b0;
    end else begin
      st <= st_next;
      if (in_fire) begin
        buttons <= buttons_next;
        axis_y  <= is_abs_y;
      end
      if (rsp.done) begin
        if (axis_y) begin
          cursor_row <= new_coord;
        end else begin
          cursor_col <= new_coord;
        end
      end
      // load the result register; in_ready guarantees it is free
      if (rsp.done) begin
        out_valid <= 1'b1;
      end else if (in_fire && !start_scale) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rsp.done) begin
      out_data.cursor_x    <= axis_y ? cursor_col : new_coord;
      out_data.cursor_y    <= axis_y ? new_coord : cursor_row;
      out_data.button_mask <= buttons;
    end else if (in_fire && !start_scale) begin
      out_data.cursor_x    <= cursor_col;
      out_data.cursor_y    <= cursor_row;
      out_data.button_mask <= buttons_next;
    end
  end

  a_done_only_when_scaling: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> (st == ST_SCALE))
    else $error("scaler finished with no axis event in flight");

  a_result_slot_free: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> !out_valid)
    else $error("scaled result would overwrite a pending result");

  a_buttons_hold: assert property (@(posedge clk) disable iff (rst)
    !in_fire |=> $stable(buttons))
    else $error("button mask changed without an input transfer");

  a_scale_blocks_input: assert property (@(posedge clk) disable iff (rst)
    start_scale |=> !in_ready)
    else $error("input taken while an axis event is being scaled");

endmodule

/* bench/tb_absolute_pointer_event_tracker_unit.sv */
`timescale 1ns / 100ps

module tb_absolute_pointer_event_tracker_unit;
  import apet_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PER_PHASE = 105;
  localparam int RANGE_PHASES = 6;

  // Tracks cursor and button state from accepted events and checks each report.
  class cursor_scoreboard;
    logic [RAW_W-1:0]   range_lo [2];
    logic [RAW_W-1:0]   range_hi [2];
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [BTN_W-1:0]   buttons;
    result_t            pending_reports [$];
    int                 mismatches;
    int                 accepted;
    int                 checked;

    function new();
      range_lo[0] = '0;
      range_hi[0] = X_MAX_RESET;
      range_lo[1] = '0;
      range_hi[1] = Y_MAX_RESET;
      col = COL_RESET;
      row = ROW_RESET;
      buttons = '0;
      mismatches = 0;
      accepted = 0;
      checked = 0;
    endfunction

    function void set_reg(reg_index_t idx, logic [RAW_W-1:0] v);
      case (idx)
        REG_X_MIN: range_lo[0] = v;
        REG_X_MAX: range_hi[0] = v;
        REG_Y_MIN: range_lo[1] = v;
        REG_Y_MAX: range_hi[1] = v;
        default: ;
      endcase
    endfunction

    // Clamp into the raw range, then map linearly onto 0..size-1 pixels.
    function logic [RAW_W-1:0] pixel_from_raw(logic [RAW_W-1:0] raw, logic [RAW_W-1:0] lo,
                                              logic [RAW_W-1:0] hi, int unsigned size);
      logic [63:0]      span;
      logic [63:0]      prod;
      logic [RAW_W-1:0] v;
      if (hi <= lo) begin
        lo = '0;
        hi = FALLBACK_MAX;
      end
      span = 64'(hi) - 64'(lo);
      if (span == 0) return '0;
      v = raw;
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      prod = (64'(v) - 64'(lo)) * 64'(size - 1);
      return RAW_W'(prod / span);
    endfunction

    function void note_event(event_t ev);
      result_t        want;
      logic [BTN_W-1:0] bit_sel;
      accepted++;
      bit_sel = '0;
      if (ev.event_type == EVT_ABS) begin
        if (ev.event_code == AXIS_X)
          col = COORD_W'(pixel_from_raw(ev.event_value, range_lo[0], range_hi[0], SCREEN_WIDTH));
        else if (ev.event_code == AXIS_Y)
          row = COORD_W'(pixel_from_raw(ev.event_value, range_lo[1], range_hi[1],
                                        SCREEN_HEIGHT));
      end else if (ev.event_type == EVT_KEY) begin
        case (ev.event_code)
          KEY_LEFT:   bit_sel = 3'b001;
          KEY_RIGHT:  bit_sel = 3'b010;
          KEY_MIDDLE: bit_sel = 3'b100;
          default:    bit_sel = 3'b000;
        endcase
        if (ev.event_value != 0) buttons = buttons | bit_sel;
        else buttons = buttons & ~bit_sel;
      end
      want.cursor_x = col;
      want.cursor_y = row;
      want.button_mask = buttons;
      pending_reports.push_back(want);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending_reports.size() == 0) begin
        report($sformatf("unexpected report x=%0d y=%0d buttons=%0h",
                         got.cursor_x, got.cursor_y, got.button_mask));
        return;
      end
      want = pending_reports.pop_front();
      checked++;
      if (got.cursor_x !== want.cursor_x)
        report($sformatf("report %0d cursor_x got %0d want %0d", checked, got.cursor_x,
                         want.cursor_x));
      if (got.cursor_y !== want.cursor_y)
        report($sformatf("report %0d cursor_y got %0d want %0d", checked, got.cursor_y,
                         want.cursor_y));
      if (got.button_mask !== want.button_mask)
        report($sformatf("report %0d button_mask got %0h want %0h", checked, got.button_mask,
                         want.button_mask));
    endtask

    function int pending();
      return pending_reports.size();
    endfunction

    task close();
      if (pending_reports.size() != 0)
        report($sformatf("%0d reports never arrived", pending_reports.size()));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  event_t               in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  result_t              out_data;
  logic                 write_enable = 1'b0;
  logic [CFG_IDX_W-1:0] register_index = '0;
  logic [RAW_W-1:0]     write_data = '0;

  cursor_scoreboard sb;
  int               idle_cycles = 0;
  int               phases_run = 0;

  absolute_pointer_event_tracker_unit dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .write_enable   (write_enable),
    .register_index (register_index),
    .write_data     (write_data)
  );

  always #2 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [RAW_W-1:0] pick_axis_value(logic [RAW_W-1:0] lo,
                                                       logic [RAW_W-1:0] hi);
    logic [63:0] width;
    if (hi <= lo) begin
      lo = '0;
      hi = FALLBACK_MAX;
    end
    width = 64'(hi) - 64'(lo) + 64'd1;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return lo + RAW_W'({$urandom, $urandom} % width);
      4: return lo;
      5: return hi;
      6: return lo - RAW_W'($urandom_range(1, 3));
      7: return hi + RAW_W'($urandom_range(1, 3));
      8: return $urandom;
      default: return $urandom_range(0, 1) ? '0 : '1;
    endcase
  endfunction

  function automatic event_t random_event();
    event_t ev;
    int     r;
    int     axis;
    r = $urandom_range(0, 99);
    ev.event_type = 16'($urandom);
    ev.event_code = 16'($urandom);
    ev.event_value = $urandom;
    if (r < 50) begin
      axis = $urandom_range(0, 1);
      ev.event_type = EVT_ABS;
      ev.event_code = axis ? AXIS_Y : AXIS_X;
      ev.event_value = pick_axis_value(sb.range_lo[axis], sb.range_hi[axis]);
    end else if (r < 75) begin
      ev.event_type = EVT_KEY;
      case ($urandom_range(0, 2))
        0: ev.event_code = KEY_LEFT;
        1: ev.event_code = KEY_RIGHT;
        default: ev.event_code = KEY_MIDDLE;
      endcase
      if ($urandom_range(0, 2) == 0) ev.event_value = '0;
      else if ($urandom_range(0, 1)) ev.event_value = 32'd1;
    end else if (r < 83) begin
      ev.event_type = EVT_SYNC;
      if ($urandom_range(0, 3) != 0) ev.event_code = '0;
    end else if (r < 88) begin
      ev.event_type = EVT_ABS;
    end else if (r < 93) begin
      ev.event_type = EVT_KEY;
      if ($urandom_range(0, 1)) ev.event_code = KEY_LEFT - 16'd2 + 16'($urandom_range(0, 7));
    end
    return ev;
  endfunction

  // Present one event and hold it until the transfer; valid stays up across back-to-back events.
  task automatic send_event(event_t ev, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= ev;
    do @(posedge clk); while (!in_ready);
    sb.note_event(ev);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_ranges(logic [RAW_W-1:0] x_lo, logic [RAW_W-1:0] x_hi,
                              logic [RAW_W-1:0] y_lo, logic [RAW_W-1:0] y_hi);
    reg_index_t       idx [4];
    logic [RAW_W-1:0] val [4];
    idx = '{REG_X_MIN, REG_X_MAX, REG_Y_MIN, REG_Y_MAX};
    val = '{x_lo, x_hi, y_lo, y_hi};
    for (int i = 0; i < 4; i++) begin
      write_enable <= 1'b1;
      register_index <= idx[i];
      write_data <= val[i];
      @(posedge clk);
      sb.set_reg(idx[i], val[i]);
    end
    write_enable <= 1'b0;
  endtask

  task automatic program_phase(int p);
    logic [RAW_W-1:0] xl;
    logic [RAW_W-1:0] yl;
    xl = $urandom;
    yl = $urandom;
    case (p)
      1: write_ranges('0, '1, '0, '1);
      2: write_ranges('1, '0, 32'd5, 32'd5);
      3: write_ranges(32'd1000, 32'd1001, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
      4: write_ranges(xl, $urandom, yl, $urandom);
      5: write_ranges(xl, xl + RAW_W'($urandom_range(1, 5000)),
                      yl, yl + RAW_W'($urandom_range(1, 5000)));
      default: write_ranges('0, FALLBACK_MAX, 32'h100, 32'hFFFF_FF00);
    endcase
    phases_run++;
  endtask

  task automatic run_directed();
    event_t plan [$];
    plan = '{
      '{EVT_SYNC, 16'h0000, 32'h0},
      '{EVT_ABS, AXIS_X, 32'h0},
      '{EVT_ABS, AXIS_X, 32'h0000_FFFF},
      '{EVT_ABS, AXIS_X, 32'hFFFF_FFFF},
      '{EVT_ABS, AXIS_Y, 32'h0},
      '{EVT_ABS, AXIS_Y, 32'hFFFF_FFFF},
      '{EVT_ABS, AXIS_Y, 32'h0000_8000},
      '{EVT_ABS, 16'h0002, 32'h0000_1234},
      '{EVT_ABS, 16'hFFFF, 32'h0},
      '{EVT_KEY, KEY_LEFT, 32'h1},
      '{EVT_KEY, KEY_RIGHT, 32'hFFFF_FFFF},
      '{EVT_KEY, KEY_MIDDLE, 32'h8000_0000},
      '{EVT_KEY, KEY_LEFT, 32'h0},
      '{EVT_KEY, 16'h0113, 32'h1},
      '{EVT_KEY, 16'h010F, 32'h1},
      '{EVT_KEY, 16'hFFFF, 32'h1},
      '{EVT_KEY, KEY_RIGHT, 32'h0},
      '{EVT_KEY, KEY_MIDDLE, 32'h0},
      '{16'h0002, 16'h0000, 32'h5},
      '{16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF},
      '{EVT_ABS, AXIS_X, 32'h0000_7FFF},
      '{16'h0103, AXIS_X, 32'h0},
      '{16'h8001, KEY_LEFT, 32'h1},
      '{EVT_ABS, AXIS_X, 32'h1}
    };
    foreach (plan[i]) send_event(plan[i], pick_gap(1'b0));
  endtask

  task automatic run_random(int count);
    bit steady;
    steady = 1'b0;
    for (int i = 0; i < count; i++) begin
      if (i % 25 == 0) steady = ($urandom_range(0, 3) == 0);
      send_event(random_event(), pick_gap(steady));
    end
  endtask

  // Receiver: ready runs, mostly short, sometimes long, broken by random stalls.
  initial begin
    int run;
    int gap;
    @(posedge clk);
    forever begin
      run = ($urandom_range(0, 99) < 20) ? $urandom_range(30, 80) : $urandom_range(1, 6);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      gap = pick_gap(1'b0);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  // Watchdog: count cycles with no transfer on either channel and no register write.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || write_enable) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    drain();
    for (int p = 1; p <= RANGE_PHASES; p++) begin
      program_phase(p);
      run_random(RANDOM_PER_PHASE);
      drain();
    end
    // Keep the clock running past the drain to catch any stray report.
    repeat (2 * MUL_W + 10) @(posedge clk);
    sb.close();
    $display("Covered %0d events across the reset ranges and %0d programmed range settings.",
             sb.accepted, phases_run);
    $display("Compared %0d reports field by field; %0d mismatches.", sb.checked,
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* absolute_pointer_event_tracker_unit.f */
hw/rtl/apet_pkg.sv
hw/rtl/apet_scaler.sv
hw/rtl/absolute_pointer_event_tracker_unit.sv
bench/tb_absolute_pointer_event_tracker_unit.sv
